>>> src/two_level_queue_scheduler_top_defines.svh
// assertion macros used by the scheduler top
`ifndef TWO_LEVEL_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`define TWO_LEVEL_QUEUE_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TLQS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication, checked out of reset
`define TLQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

>>> src/tlqs_pkg.sv
// types and constants of the two-level queue scheduler
`default_nettype none

package tlqs_pkg;

    localparam int BURST_W = 16;
    localparam int IDX_W   = 5;
    localparam int JOB_W   = 6;
    localparam int ACT_W   = 2;

    localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd4;

    localparam logic [ACT_W-1:0] ACT_LOAD_SYS = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_USR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SCHED    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE     = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load_sys;
        logic load_usr;
        logic sched_start;
        logic sched_exec;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_status;

endpackage

`default_nettype wire

>>> src/two_level_queue_scheduler_top.sv
// two-level queue scheduler: fcfs system queue over a round-robin user queue
//
// input channel i_valid/o_ready carries one word {i_action, i_burst}: load a
// system job, load a user job, or schedule one slice. Output channel
// o_valid/i_ready carries one result word per load or schedule; the unused
// action code is taken and gives no result.
// A load's result is valid the cycle after it is taken.
// A schedule reads the queue head from a registered memory port, so after
// acceptance it passes through S_EXEC and its result is registered from there.
// Throughput: one load per cycle while the output is not stalled; no new word is taken while a schedule is in S_EXEC.
// The result sits in an output register; a new word is taken while that
// result is being taken in the same cycle, and held off while it stalls.
// i_cfg_wr_en writes the user quantum (0 acts as 1); write it only while idle.
// Synchronous reset empties both queues, clears the job counters and sets
// the quantum to 4; no memory clearing pass is needed.
`default_nettype none

`include "two_level_queue_scheduler_top_defines.svh"

module two_level_queue_scheduler_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire [tlqs_pkg::ACT_W-1:0]      i_action,
    input  wire [tlqs_pkg::BURST_W-1:0]    i_burst,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic                           o_idle,
    output logic                           o_from_user,
    output logic [tlqs_pkg::JOB_W-1:0]     o_job_id,
    output logic [tlqs_pkg::BURST_W-1:0]   o_run_time,
    output logic                           o_finished,
    output logic                           o_load_dropped,
    input  wire                            i_cfg_wr_en,
    input  wire [tlqs_pkg::BURST_W-1:0]    i_cfg_wr_data
);
    import tlqs_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    tlqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_action    (i_action),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_ready     (o_ready),
        .o_cmd       (cmd)
    );

    tlqs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_burst        (i_burst),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_out_ready    (i_ready),
        .o_status       (status),
        .o_idle         (o_idle),
        .o_from_user    (o_from_user),
        .o_job_id       (o_job_id),
        .o_run_time     (o_run_time),
        .o_finished     (o_finished),
        .o_load_dropped (o_load_dropped)
    );

    assign o_valid = status.out_valid;

    `TLQS_ASSERT_NEXT(a_exec_follows_start, cmd.sched_start, cmd.sched_exec)
    `TLQS_ASSERT_NOW(a_no_accept_in_exec, cmd.sched_exec, !o_ready)
    `TLQS_ASSERT_NEXT(a_result_after_exec, cmd.sched_exec, o_valid)
    `TLQS_ASSERT_NEXT(a_load_gives_result, cmd.load_sys || cmd.load_usr, o_valid)
    `TLQS_ASSERT_NOW(a_drop_only_on_load, o_valid && o_load_dropped,
                     !o_idle && !o_finished && !o_from_user)

endmodule

`default_nettype wire

>>> src/tlqs_ctrl.sv
// controller: input handshake and schedule sequencing
`default_nettype none

module tlqs_ctrl (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    input  wire [tlqs_pkg::ACT_W-1:0]      i_action,
    input  wire                            i_out_ready,
    input  wire tlqs_pkg::t_dp_status      i_status,
    output logic                           o_ready,
    output tlqs_pkg::t_dp_cmd              o_cmd
);
    import tlqs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        accept  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                // output register must be free or emptying this cycle
                o_ready = !i_status.out_valid || i_out_ready;
                accept  = o_ready && i_valid;
                o_cmd.load_sys    = accept && (i_action == ACT_LOAD_SYS);
                o_cmd.load_usr    = accept && (i_action == ACT_LOAD_USR);
                o_cmd.sched_start = accept && (i_action == ACT_SCHED);
                if (o_cmd.sched_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.sched_exec = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/tlqs_datapath.sv
// datapath: queue memories, pointers, job counters, quantum and result register
`default_nettype none

module tlqs_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire tlqs_pkg::t_dp_cmd         i_cmd,
    input  wire [tlqs_pkg::BURST_W-1:0]    i_burst,
    input  wire                            i_cfg_wr_en,
    input  wire [tlqs_pkg::BURST_W-1:0]    i_cfg_wr_data,
    input  wire                            i_out_ready,
    output tlqs_pkg::t_dp_status           o_status,
    output logic                           o_idle,
    output logic                           o_from_user,
    output logic [tlqs_pkg::JOB_W-1:0]     o_job_id,
    output logic [tlqs_pkg::BURST_W-1:0]   o_run_time,
    output logic                           o_finished,
    output logic                           o_load_dropped
);
    import tlqs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = IDX_W + BURST_W;
    localparam logic [CNT_W-1:0] FULL     = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    logic [ENT_W-1:0] sys_mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] usr_mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] r_sys_rd;
    logic [ENT_W-1:0] r_usr_rd;

    logic [PTR_W-1:0]   r_sys_head, n_sys_head;
    logic [PTR_W-1:0]   r_usr_head, n_usr_head;
    logic [CNT_W-1:0]   r_sys_fill, n_sys_fill;
    logic [CNT_W-1:0]   r_usr_fill, n_usr_fill;
    logic [IDX_W-1:0]   r_sys_loaded, n_sys_loaded;
    logic [IDX_W-1:0]   r_usr_loaded, n_usr_loaded;
    logic [BURST_W-1:0] r_quantum;
    logic               r_out_valid, n_out_valid;

    logic               r_idle, n_idle;
    logic               r_from_user, n_from_user;
    logic [JOB_W-1:0]   r_job_id, n_job_id;
    logic [BURST_W-1:0] r_run_time, n_run_time;
    logic               r_finished, n_finished;
    logic               r_dropped, n_dropped;
    logic               out_load;

    logic [PTR_W-1:0]   sys_tail, usr_tail;
    logic [CNT_W:0]     sys_sum, usr_sum;
    logic               sys_we, usr_we;
    logic [ENT_W-1:0]   usr_wdata;
    logic [BURST_W-1:0] eff_q;
    logic [BURST_W-1:0] usr_burst;
    logic [IDX_W-1:0]   usr_idx;

    // tail slot = (head + fill) mod depth
    assign sys_sum  = (CNT_W+1)'(r_sys_head) + (CNT_W+1)'(r_sys_fill);
    assign usr_sum  = (CNT_W+1)'(r_usr_head) + (CNT_W+1)'(r_usr_fill);
    assign sys_tail = (sys_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                      PTR_W'(sys_sum - (CNT_W+1)'(QUEUE_DEPTH)) : PTR_W'(sys_sum);
    assign usr_tail = (usr_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                      PTR_W'(usr_sum - (CNT_W+1)'(QUEUE_DEPTH)) : PTR_W'(usr_sum);

    assign eff_q     = (r_quantum == '0) ? BURST_W'(1) : r_quantum;
    assign usr_burst = r_usr_rd[BURST_W-1:0];
    assign usr_idx   = r_usr_rd[ENT_W-1:BURST_W];

    always_comb begin
        n_sys_head   = r_sys_head;
        n_usr_head   = r_usr_head;
        n_sys_fill   = r_sys_fill;
        n_usr_fill   = r_usr_fill;
        n_sys_loaded = r_sys_loaded;
        n_usr_loaded = r_usr_loaded;
        n_idle       = 1'b0;
        n_from_user  = 1'b0;
        n_job_id     = '0;
        n_run_time   = '0;
        n_finished   = 1'b0;
        n_dropped    = 1'b0;
        sys_we       = 1'b0;
        usr_we       = 1'b0;
        usr_wdata    = {n_usr_loaded, i_burst};
        out_load     = i_cmd.load_sys || i_cmd.load_usr || i_cmd.sched_exec;

        if (i_cmd.load_sys) begin
            if (r_sys_fill == FULL) begin
                n_dropped = 1'b1;
            end else begin
                sys_we       = 1'b1;
                n_sys_loaded = r_sys_loaded + IDX_W'(1);
                n_sys_fill   = r_sys_fill + CNT_W'(1);
            end
        end else if (i_cmd.load_usr) begin
            if (r_usr_fill == FULL) begin
                n_dropped = 1'b1;
            end else begin
                usr_we       = 1'b1;
                n_usr_loaded = r_usr_loaded + IDX_W'(1);
                n_usr_fill   = r_usr_fill + CNT_W'(1);
                usr_wdata    = {n_usr_loaded, i_burst};
            end
        end else if (i_cmd.sched_exec) begin
            if (r_sys_fill != '0) begin
                n_job_id   = {1'b0, r_sys_rd[ENT_W-1:BURST_W]};
                n_run_time = r_sys_rd[BURST_W-1:0];
                n_finished = 1'b1;
                n_sys_head = (r_sys_head == LAST_PTR) ? '0 : r_sys_head + PTR_W'(1);
                n_sys_fill = r_sys_fill - CNT_W'(1);
            end else if (r_usr_fill != '0) begin
                n_from_user = 1'b1;
                n_job_id    = {1'b0, r_sys_loaded} + {1'b0, usr_idx};
                n_usr_head  = (r_usr_head == LAST_PTR) ? '0 : r_usr_head + PTR_W'(1);
                if (usr_burst > eff_q) begin
                    // remainder goes back to the tail, fill unchanged
                    n_run_time = eff_q;
                    usr_we     = 1'b1;
                    usr_wdata  = {usr_idx, usr_burst - eff_q};
                end else begin
                    n_run_time = usr_burst;
                    n_finished = 1'b1;
                    n_usr_fill = r_usr_fill - CNT_W'(1);
                end
            end else begin
                n_idle = 1'b1;
            end
        end

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // queue memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (sys_we) begin
            sys_mem[sys_tail] <= {n_sys_loaded, i_burst};
        end
        if (i_cmd.sched_start) begin
            r_sys_rd <= sys_mem[r_sys_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (usr_we) begin
            usr_mem[usr_tail] <= usr_wdata;
        end
        if (i_cmd.sched_start) begin
            r_usr_rd <= usr_mem[r_usr_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_head   <= '0;
            r_usr_head   <= '0;
            r_sys_fill   <= '0;
            r_usr_fill   <= '0;
            r_sys_loaded <= '0;
            r_usr_loaded <= '0;
            r_quantum    <= QUANTUM_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_sys_head   <= n_sys_head;
            r_usr_head   <= n_usr_head;
            r_sys_fill   <= n_sys_fill;
            r_usr_fill   <= n_usr_fill;
            r_sys_loaded <= n_sys_loaded;
            r_usr_loaded <= n_usr_loaded;
            r_out_valid  <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_quantum <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_idle      <= n_idle;
            r_from_user <= n_from_user;
            r_job_id    <= n_job_id;
            r_run_time  <= n_run_time;
            r_finished  <= n_finished;
            r_dropped   <= n_dropped;
        end
    end

    assign o_status.out_valid = r_out_valid;
    assign o_idle         = r_idle;
    assign o_from_user    = r_from_user;
    assign o_job_id       = r_job_id;
    assign o_run_time     = r_run_time;
    assign o_finished     = r_finished;
    assign o_load_dropped = r_dropped;

endmodule

`default_nettype wire
